FILE: src/mrms_pkg.sv
// ----------------------------------------------------------------------------
// mrms_pkg: shared types and codes for the maze robot move sequencer
// Event, result, state and configuration types, command codes and the
// heading rotation tables used for sign walls.
// ----------------------------------------------------------------------------
package mrms_pkg;

    // Event codes
    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_ANSWER  = 3'd1;
    localparam logic [2:0] CMD_TURNED  = 3'd2;
    localparam logic [2:0] CMD_MOVED   = 3'd3;
    localparam logic [2:0] CMD_STOP    = 3'd4;
    localparam logic [2:0] CMD_AVOID_L = 3'd5;
    localparam logic [2:0] CMD_AVOID_R = 3'd6;
    localparam logic [2:0] CMD_RESUME  = 3'd7;

    // Path answer kinds
    localparam logic [1:0] ANS_DIR    = 2'd0;
    localparam logic [1:0] ANS_ERROR  = 2'd1;
    localparam logic [1:0] ANS_MAPPED = 2'd2;

    // Relative move directions
    localparam logic [2:0] DIR_STOP  = 3'd0;
    localparam logic [2:0] DIR_FWD   = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_BACK  = 3'd4;

    // Motor commands and drive modes
    localparam logic [2:0] MC_NONE  = 3'd0;
    localparam logic [2:0] MC_FWD   = 3'd1;
    localparam logic [2:0] MC_BACK  = 3'd2;
    localparam logic [2:0] MC_LEFT  = 3'd3;
    localparam logic [2:0] MC_RIGHT = 3'd4;
    localparam logic [2:0] MC_STOP  = 3'd5;

    localparam logic [1:0] MM_AUTO   = 2'd0;
    localparam logic [1:0] MM_MANUAL = 2'd1;
    localparam logic [1:0] MM_WALL   = 2'd2;

    // Camera commands
    localparam logic [2:0] CAM_NONE   = 3'd0;
    localparam logic [2:0] CAM_LINE   = 3'd1;
    localparam logic [2:0] CAM_CENTER = 3'd2;
    localparam logic [2:0] CAM_LEFT   = 3'd3;
    localparam logic [2:0] CAM_RIGHT  = 3'd4;

    // Sign recognition phases
    localparam logic [2:0] RP_START  = 3'd0;
    localparam logic [2:0] RP_BACKUP = 3'd1;
    localparam logic [2:0] RP_WAIT   = 3'd2;
    localparam logic [2:0] RP_POINT  = 3'd3;
    localparam logic [2:0] RP_DWELL  = 3'd4;

    // Wall index within the camera sweep
    localparam logic [7:0] WALL_CENTER = 8'd0;
    localparam logic [7:0] WALL_LEFT   = 8'd1;
    localparam logic [7:0] WALL_RIGHT  = 8'd2;
    localparam logic [7:0] WALL_LAST   = 8'd3;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_BACKUP = 2'd0;
    localparam logic [1:0]  CFG_DWELL  = 2'd1;
    localparam logic [1:0]  CFG_SETTLE = 2'd2;
    localparam logic [31:0] BACKUP_RESET = 32'd200000;
    localparam logic [31:0] DWELL_RESET  = 32'd2000000;
    localparam logic [31:0] SETTLE_RESET = 32'd500000;

    typedef enum logic [3:0] {
        MODE_READY    = 4'd0,
        MODE_WAITDIR  = 4'd1,
        MODE_RECEIVED = 4'd2,
        MODE_TURNING  = 4'd3,
        MODE_TURNED   = 4'd4,
        MODE_MOVING   = 4'd5,
        MODE_MOVED    = 4'd6,
        MODE_RECOG    = 4'd7,
        MODE_WAITSIGN = 4'd8,
        MODE_RESUME   = 4'd9
    } mode_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] now_us;
        logic        red_dot;
        logic        sign_seen;
        logic [1:0]  answer_kind;
        logic [2:0]  move_dir;
        logic [1:0]  heading;
    } item_t;

    typedef struct packed {
        logic [2:0] motor_cmd;
        logic [1:0] motor_mode;
        logic [2:0] cam_cmd;
        logic       fail_pulse;
        logic       request_path;
        logic       advance_position;
        logic       report_next;
        logic       sign_valid;
        logic [1:0] sign_heading;
        logic [3:0] mode_now;
        logic       last;
    } result_t;

    typedef struct packed {
        mode_t       mode;
        logic [2:0]  chosen_dir;
        logic        mapped_done;
        logic [2:0]  recog_phase;
        logic [7:0]  wall_count;
        logic [31:0] phase_start;
    } state_t;

    typedef struct packed {
        logic [31:0] backup_time_us;
        logic [31:0] dwell_time_us;
        logic [31:0] settle_time_us;
    } cfg_t;

    // Heading of the left wall for a given heading
    function automatic logic [1:0] rot_left(input logic [1:0] h);
        logic [1:0] r;
        case (h)
            2'd0:    r = 2'd3;
            2'd1:    r = 2'd2;
            2'd2:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    // Heading of the right wall for a given heading
    function automatic logic [1:0] rot_right(input logic [1:0] h);
        logic [1:0] r;
        case (h)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd3;
            2'd2:    r = 2'd1;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/mrms_step.sv
// ----------------------------------------------------------------------------
// mrms_step: event decode and next-state logic
// Combinational: takes one event and the current state, gives the next
// state and one or two result beats.
// ----------------------------------------------------------------------------
module mrms_step
    import mrms_pkg::*;
(
    input  item_t   item,
    input  state_t  st,
    input  cfg_t    cfg,
    output state_t  st_next,
    output result_t res0,
    output result_t res1,
    output logic    two
);

    always_comb begin
        state_t      s;
        result_t     r0;
        result_t     r1;
        logic        two_v;
        logic [31:0] elapsed;
        logic        sv;
        logic [1:0]  sh;

        s       = st;
        r0      = '0;
        r1      = '0;
        two_v   = 1'b0;
        sv      = 1'b0;
        sh      = 2'd0;
        elapsed = item.now_us - st.phase_start;

        case (item.cmd)
            CMD_TICK: begin
                case (st.mode)
                    MODE_READY: begin
                        if (!st.mapped_done) begin
                            r0.request_path = 1'b1;
                            s.mode = MODE_WAITDIR;
                        end
                    end
                    MODE_WAITDIR, MODE_TURNING: begin
                    end
                    MODE_RECEIVED: begin
                        r0.motor_mode = MM_AUTO;
                        case (st.chosen_dir)
                            DIR_FWD: begin
                                r0.motor_cmd = MC_FWD;
                                s.mode = MODE_MOVING;
                            end
                            DIR_LEFT: begin
                                r0.motor_cmd = MC_LEFT;
                                s.mode = MODE_TURNING;
                            end
                            DIR_RIGHT: begin
                                r0.motor_cmd = MC_RIGHT;
                                s.mode = MODE_TURNING;
                            end
                            DIR_BACK: begin
                                r0.motor_cmd = MC_BACK;
                                s.mode = MODE_TURNING;
                            end
                            DIR_STOP: begin
                                r0.motor_cmd = MC_STOP;
                                s.mode = MODE_READY;
                            end
                            default: begin
                                r0.motor_cmd = MC_STOP;
                                r0.fail_pulse = 1'b1;
                                s.mode = MODE_READY;
                            end
                        endcase
                    end
                    MODE_TURNED: begin
                        r0.motor_mode = MM_AUTO;
                        if (st.chosen_dir >= DIR_LEFT && st.chosen_dir <= DIR_BACK) begin
                            r0.motor_cmd = MC_FWD;
                            s.mode = MODE_MOVING;
                        end else begin
                            r0.motor_cmd = MC_STOP;
                            r0.fail_pulse = 1'b1;
                            s.mode = MODE_READY;
                        end
                    end
                    MODE_MOVING: begin
                        if (item.red_dot) begin
                            s.mode = MODE_RECOG;
                        end
                    end
                    MODE_MOVED: begin
                        s.mode = MODE_READY;
                    end
                    MODE_RECOG: begin
                        case (st.recog_phase)
                            RP_START: begin
                                s.phase_start = item.now_us;
                                s.recog_phase = RP_BACKUP;
                            end
                            RP_BACKUP: begin
                                r0.motor_cmd  = MC_BACK;
                                r0.motor_mode = MM_MANUAL;
                                s.recog_phase = RP_WAIT;
                            end
                            RP_WAIT: begin
                                if (elapsed > cfg.backup_time_us) begin
                                    r0.motor_cmd  = MC_STOP;
                                    r0.motor_mode = MM_MANUAL;
                                    s.phase_start = item.now_us;
                                    s.recog_phase = RP_POINT;
                                end
                            end
                            RP_POINT: begin
                                case (st.wall_count)
                                    WALL_CENTER: r0.cam_cmd = CAM_CENTER;
                                    WALL_LEFT:   r0.cam_cmd = CAM_LEFT;
                                    WALL_RIGHT:  r0.cam_cmd = CAM_RIGHT;
                                    default:     r0.cam_cmd = CAM_NONE;
                                endcase
                                s.recog_phase = RP_DWELL;
                            end
                            RP_DWELL: begin
                                if (elapsed > cfg.dwell_time_us) begin
                                    s.phase_start = item.now_us;
                                    s.wall_count  = st.wall_count + 8'd1;
                                    s.recog_phase = RP_POINT;
                                end
                            end
                            default: begin
                            end
                        endcase

                        // Phase start is unchanged whenever we land in dwell, so the
                        // shared elapsed time serves the settle check as well.
                        if (item.sign_seen && s.recog_phase == RP_DWELL &&
                            elapsed > cfg.settle_time_us) begin
                            case (s.wall_count)
                                WALL_CENTER: begin
                                    sv = 1'b1;
                                    sh = item.heading;
                                end
                                WALL_LEFT: begin
                                    sv = 1'b1;
                                    sh = rot_left(item.heading);
                                end
                                WALL_RIGHT: begin
                                    sv = 1'b1;
                                    sh = rot_right(item.heading);
                                end
                                default: begin
                                    sv = 1'b0;
                                    sh = 2'd0;
                                end
                            endcase
                            if (r0.cam_cmd != CAM_NONE) begin
                                two_v           = 1'b1;
                                r1.sign_valid   = sv;
                                r1.sign_heading = sh;
                                r1.cam_cmd      = CAM_LINE;
                            end else begin
                                r0.sign_valid   = sv;
                                r0.sign_heading = sh;
                                r0.cam_cmd      = CAM_LINE;
                            end
                            s.mode        = MODE_RESUME;
                            s.recog_phase = RP_START;
                            s.wall_count  = WALL_CENTER;
                        end

                        if (s.wall_count > WALL_LAST) begin
                            r0.fail_pulse = 1'b1;
                            s.mode = MODE_READY;
                        end
                    end
                    MODE_WAITSIGN: begin
                        s.mode = MODE_RESUME;
                    end
                    MODE_RESUME: begin
                        r0.motor_cmd        = MC_FWD;
                        r0.motor_mode       = MM_MANUAL;
                        r1.motor_cmd        = MC_STOP;
                        r1.motor_mode       = MM_MANUAL;
                        r1.advance_position = 1'b1;
                        two_v  = 1'b1;
                        s.mode = MODE_READY;
                    end
                    default: begin
                        r0.fail_pulse = 1'b1;
                    end
                endcase
            end
            CMD_ANSWER: begin
                case (item.answer_kind)
                    ANS_ERROR: begin
                        r0.fail_pulse = 1'b1;
                        s.mode = MODE_READY;
                    end
                    ANS_MAPPED: begin
                        s.mapped_done = 1'b1;
                        s.mode = MODE_READY;
                        r0.motor_cmd  = MC_STOP;
                        r0.motor_mode = MM_AUTO;
                    end
                    default: begin
                        s.chosen_dir   = item.move_dir;
                        s.mode         = MODE_RECEIVED;
                        r0.report_next = 1'b1;
                    end
                endcase
            end
            CMD_TURNED: begin
                if (st.mode == MODE_TURNING) begin
                    s.mode = MODE_TURNED;
                end
            end
            CMD_MOVED: begin
                if (st.mode == MODE_MOVING) begin
                    s.mode = MODE_MOVED;
                    r0.advance_position = !item.red_dot;
                end
            end
            CMD_STOP: begin
                if (st.mode == MODE_MOVING) begin
                    r0.motor_cmd  = MC_STOP;
                    r0.motor_mode = MM_AUTO;
                    r0.fail_pulse = 1'b1;
                    s.mode = MODE_READY;
                end
            end
            CMD_AVOID_L: begin
                if (st.chosen_dir == DIR_FWD || st.chosen_dir == DIR_LEFT) begin
                    r0.motor_cmd  = MC_RIGHT;
                    r0.motor_mode = MM_WALL;
                end
            end
            CMD_AVOID_R: begin
                if (st.chosen_dir == DIR_FWD || st.chosen_dir == DIR_RIGHT) begin
                    r0.motor_cmd  = MC_LEFT;
                    r0.motor_mode = MM_WALL;
                end
            end
            default: begin
                r0.advance_position = 1'b1;
                r0.motor_cmd  = MC_STOP;
                r0.motor_mode = MM_AUTO;
                r0.cam_cmd    = CAM_LINE;
                s.mode        = MODE_READY;
                s.chosen_dir  = DIR_STOP;
                s.mapped_done = 1'b0;
            end
        endcase

        r0.mode_now = s.mode;
        r1.mode_now = s.mode;
        r0.last     = !two_v;
        r1.last     = 1'b1;

        st_next = s;
        res0    = r0;
        res1    = r1;
        two     = two_v;
    end

endmodule

FILE: src/mrms_out_buf.sv
// ----------------------------------------------------------------------------
// mrms_out_buf: two-slot result buffer
// Holds the one or two result beats of an event and presents them in order.
// ----------------------------------------------------------------------------
module mrms_out_buf
    import mrms_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  logic    push_two,
    input  result_t push_res0,
    input  result_t push_res1,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_res   = slot0_reg;
    assign pop       = out_valid && out_ready;
    // Both slots are free after this edge: empty, or the only beat leaves now.
    assign room      = (count_reg == 2'd0) || (count_reg == 2'd1 && out_ready);

    always_comb begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        if (push) begin
            slot0_next = push_res0;
            slot1_next = push_res1;
            count_next = push_two ? 2'd2 : 2'd1;
        end else if (pop) begin
            slot0_next = slot1_reg;
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

FILE: src/maze_robot_move_sequencer.sv
// ----------------------------------------------------------------------------
// maze_robot_move_sequencer: cell-by-cell motion sequencer
// Turns robot events into motor and camera commands, path requests and
// position/fail pulses, with a timed sign-recognition sweep on red-dot cells.
// ----------------------------------------------------------------------------
//
//  Channel  | Ports                       | Beat
//  ---------+-----------------------------+-----------------------------------
//  event in | s_valid/s_ready, s_*        | one event with its time stamp
//  result   | m_valid/m_ready, m_*        | one command set; m_last ends event
//  config   | cfg_wr_en, cfg_index, wdata | one 32-bit timing register write
//
//  An accepted event is held in the input register, is decoded there and its
//  one or two result beats are registered in the two-slot result buffer;
//  one event can be taken every cycle as long as each yields one beat that is
//  taken at once. The result buffer sets the rate: an event needs both slots
//  free, so a two-beat event or a stalled m_ready holds the input register,
//  then s_ready. Reset (aresetn low, synchronous) clears mode, flags, timers,
//  buffers and loads the default timing registers.
// ----------------------------------------------------------------------------
module maze_robot_move_sequencer
    import mrms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [31:0] s_now_us,
    input  logic        s_red_dot,
    input  logic        s_sign_seen,
    input  logic [1:0]  s_answer_kind,
    input  logic [2:0]  s_move_dir,
    input  logic [1:0]  s_heading,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_motor_cmd,
    output logic [1:0]  m_motor_mode,
    output logic [2:0]  m_cam_cmd,
    output logic        m_fail_pulse,
    output logic        m_request_path,
    output logic        m_advance_position,
    output logic        m_report_next,
    output logic        m_sign_valid,
    output logic [1:0]  m_sign_heading,
    output logic [3:0]  m_mode_now,
    output logic        m_last
);

    cfg_t    cfg_reg, cfg_next;
    state_t  state_reg, state_next;
    state_t  step_state;
    item_t   item_reg, item_next;
    logic    in_valid_reg, in_valid_next;
    logic    room;
    logic    process;
    logic    two;
    result_t res0, res1;
    result_t out_res;

    // Process the held event once the result buffer has room for two beats.
    assign process = in_valid_reg && room;
    assign s_ready = !in_valid_reg || process;

    // Timing registers: write whenever the enable is high, ignore index three.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_BACKUP: cfg_next.backup_time_us = cfg_wdata;
                CFG_DWELL:  cfg_next.dwell_time_us  = cfg_wdata;
                CFG_SETTLE: cfg_next.settle_time_us = cfg_wdata;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    // Input register: load on accept, drop once processed.
    always_comb begin
        in_valid_next = in_valid_reg;
        item_next     = item_reg;
        if (s_valid && s_ready) begin
            in_valid_next       = 1'b1;
            item_next.cmd         = s_cmd;
            item_next.now_us      = s_now_us;
            item_next.red_dot     = s_red_dot;
            item_next.sign_seen   = s_sign_seen;
            item_next.answer_kind = s_answer_kind;
            item_next.move_dir    = s_move_dir;
            item_next.heading     = s_heading;
        end else if (process) begin
            in_valid_next = 1'b0;
        end
    end

    // Advance the sequencer state only on the cycle the event is processed.
    assign state_next = process ? step_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.backup_time_us <= BACKUP_RESET;
            cfg_reg.dwell_time_us  <= DWELL_RESET;
            cfg_reg.settle_time_us <= SETTLE_RESET;
            in_valid_reg           <= 1'b0;
            state_reg.mode         <= MODE_READY;
            state_reg.chosen_dir   <= DIR_STOP;
            state_reg.mapped_done  <= 1'b0;
            state_reg.recog_phase  <= RP_START;
            state_reg.wall_count   <= WALL_CENTER;
            state_reg.phase_start  <= 32'd0;
        end else begin
            cfg_reg      <= cfg_next;
            in_valid_reg <= in_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    mrms_step u_step (
        .item    (item_reg),
        .st      (state_reg),
        .cfg     (cfg_reg),
        .st_next (step_state),
        .res0    (res0),
        .res1    (res1),
        .two     (two)
    );

    mrms_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (process),
        .push_two  (two),
        .push_res0 (res0),
        .push_res1 (res1),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_motor_cmd        = out_res.motor_cmd;
    assign m_motor_mode       = out_res.motor_mode;
    assign m_cam_cmd          = out_res.cam_cmd;
    assign m_fail_pulse       = out_res.fail_pulse;
    assign m_request_path     = out_res.request_path;
    assign m_advance_position = out_res.advance_position;
    assign m_report_next      = out_res.report_next;
    assign m_sign_valid       = out_res.sign_valid;
    assign m_sign_heading     = out_res.sign_heading;
    assign m_mode_now         = out_res.mode_now;
    assign m_last             = out_res.last;

endmodule
